FILE: sv/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types, initial hash values and round helpers for the SHA-1 block
// compression engine.
// ----------------------------------------------------------------------------
package sbc_pkg;

    localparam int WORD_W = 32;
    localparam int DIGEST_WORDS = 5;
    localparam int BLOCK_WORDS = 16;

    localparam logic [6:0] LAST_ROUND      = 7'd79;
    localparam logic [6:0] STAGE1_ROUND    = 7'd20;
    localparam logic [6:0] STAGE2_ROUND    = 7'd40;
    localparam logic [6:0] STAGE3_ROUND    = 7'd60;
    localparam logic [2:0] LAST_DIGEST_IDX = 3'd4;
    localparam logic [3:0] LAST_BLOCK_WORD = 4'd15;

    localparam logic [WORD_W-1:0] K_STAGE0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_STAGE1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_STAGE2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_STAGE3 = 32'hCA62C1D6;

    // Input item as seen on the command port
    typedef struct packed {
        logic [31:0] message_word;
        logic        message_start;
        logic        message_end;
    } t_msg_item;

    // One digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  digest_index;
        logic        digest_last;
    } t_digest_item;

    // Classified word handed from the front end to the compression core
    typedef struct packed {
        logic [31:0] word;
        logic        restart;     // reload initial hash before this word
        logic        block_done;  // this word completes a 16-word block
        logic        emit;        // put out the digest after this block
    } t_work;

    typedef logic [DIGEST_WORDS-1:0][WORD_W-1:0] t_chain;

    // Entry 0 is the most significant digest word
    localparam t_chain INIT_HASH = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_FOLD,
        CORE_EMIT
    } t_core_state;

    // Round function plus round constant for round t
    function automatic logic [WORD_W-1:0] round_fk(
        input logic [6:0]        t,
        input logic [WORD_W-1:0] b,
        input logic [WORD_W-1:0] c,
        input logic [WORD_W-1:0] d
    );
        logic [WORD_W-1:0] f;
        logic [WORD_W-1:0] k;
        priority if (t < STAGE1_ROUND) begin
            f = d ^ (b & (c ^ d));
            k = K_STAGE0;
        end else if (t < STAGE2_ROUND) begin
            f = b ^ c ^ d;
            k = K_STAGE1;
        end else if (t < STAGE3_ROUND) begin
            f = (b & c) | (d & (b | c));
            k = K_STAGE2;
        end else begin
            f = b ^ c ^ d;
            k = K_STAGE3;
        end
        return f + k;
    endfunction

endpackage

FILE: sv/sha1_block_compress.sv
// ----------------------------------------------------------------------------
// sha1_block_compress
// SHA-1 compression of an already padded stream of big-endian 32-bit words.
// ----------------------------------------------------------------------------
// Words enter on start while busy is low and wait in a small queue. The
// single round unit of the core takes one queued word per cycle while it is
// idle, then runs the rounds and the chaining add for each 16-word block
// before it takes the next word, and streams the digest after a block that
// carries the end flag. Busy rises only while the queue is full. Digest
// words come out on o_strobe, one per cycle in order with index 0 to 4, and
// cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module sha1_block_compress
    import sbc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    input  t_msg_item    i_item,
    output logic         busy,
    output logic         o_strobe,
    output t_digest_item o_result
);

    logic  push;
    logic  full;
    logic  q_valid;
    logic  pop;
    t_work work_in;
    t_work work_head;

    sbc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .i_full  (full),
        .o_busy  (busy),
        .o_push  (push),
        .o_work  (work_in)
    );

    sbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (work_in),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (full),
        .o_head  (work_head)
    );

    sbc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_head   (work_head),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

FILE: sv/sbc_front.sv
// ----------------------------------------------------------------------------
// sbc_front
// Accepts message words, tracks the position within the current block and
// tags each word for the compression core.
// ----------------------------------------------------------------------------
module sbc_front
    import sbc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_msg_item i_item,
    input  logic      i_full,
    output logic      o_busy,
    output logic      o_push,
    output t_work     o_work
);

    logic [3:0] r_word_cnt;
    logic [3:0] n_word_cnt;
    logic [3:0] slot;

    // Hold off new items while the queue is full
    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

    // A start flag restarts collection at word zero
    always_comb begin
        slot            = i_item.message_start ? 4'd0 : r_word_cnt;
        n_word_cnt      = slot + 4'd1;
        o_work.word       = i_item.message_word;
        o_work.restart    = i_item.message_start;
        o_work.block_done = (slot == LAST_BLOCK_WORD);
        o_work.emit       = (slot == LAST_BLOCK_WORD) && i_item.message_end;
    end

    // Advance the word position on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_cnt <= 4'd0;
        end else if (o_push) begin
            r_word_cnt <= n_word_cnt;
        end
    end

endmodule

FILE: sv/sbc_queue.sv
// ----------------------------------------------------------------------------
// sbc_queue
// Small first-in first-out buffer of classified words between the front end
// and the compression core.
// ----------------------------------------------------------------------------
module sbc_queue
    import sbc_pkg::*;
#(
    parameter int DEPTH = 4
)(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    input  logic  i_pop,
    output logic  o_valid,
    output logic  o_full,
    output t_work o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    t_work          r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_head  = r_mem[r_rd];

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

FILE: sv/sbc_core.sv
// ----------------------------------------------------------------------------
// sbc_core
// SHA-1 compression core: shifts words into the schedule window, runs one
// round per cycle, folds into the chaining value and streams the digest.
// ----------------------------------------------------------------------------
module sbc_core
    import sbc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  t_work        i_head,
    output logic         o_pop,
    output logic         o_strobe,
    output t_digest_item o_result
);

    t_core_state r_state;
    t_core_state n_state;

    logic [BLOCK_WORDS-1:0][WORD_W-1:0] r_win;
    t_chain                             r_chain;
    t_chain                             r_vars;
    t_chain                             fold_sum;
    t_chain                             base_chain;
    logic [6:0]                         r_round;
    logic [2:0]                         r_idx;
    logic                               r_emit;

    logic              load_word;
    logic              start_block;
    logic              do_round;
    logic              do_fold;
    logic [WORD_W-1:0] w_cur;
    logic [WORD_W-1:0] w_mix;
    logic [WORD_W-1:0] w_next;
    logic [WORD_W-1:0] a_rot;
    logic [WORD_W-1:0] t_sum;

    // Next state and control
    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        o_strobe    = 1'b0;
        load_word   = 1'b0;
        start_block = 1'b0;
        do_round    = 1'b0;
        do_fold     = 1'b0;
        unique case (r_state)
            CORE_IDLE: begin
                if (i_valid) begin
                    o_pop     = 1'b1;
                    load_word = 1'b1;
                    if (i_head.block_done) begin
                        start_block = 1'b1;
                        n_state     = CORE_ROUND;
                    end
                end
            end
            CORE_ROUND: begin
                do_round = 1'b1;
                if (r_round == LAST_ROUND) begin
                    n_state = CORE_FOLD;
                end
            end
            CORE_FOLD: begin
                do_fold = 1'b1;
                n_state = r_emit ? CORE_EMIT : CORE_IDLE;
            end
            CORE_EMIT: begin
                o_strobe = 1'b1;
                if (r_idx == LAST_DIGEST_IDX) begin
                    n_state = CORE_IDLE;
                end
            end
            default: begin
                n_state = CORE_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CORE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Round datapath: window tap 0 is always the word for this round
    always_comb begin
        w_cur  = r_win[0];
        w_mix  = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
        w_next = {w_mix[30:0], w_mix[31]};
        a_rot  = {r_vars[0][26:0], r_vars[0][31:27]};
        t_sum  = a_rot + round_fk(r_round, r_vars[1], r_vars[2], r_vars[3])
               + r_vars[4] + w_cur;
        base_chain = i_head.restart ? INIT_HASH : r_chain;
        for (int k = 0; k < DIGEST_WORDS; k++) begin
            fold_sum[k] = r_chain[k] + r_vars[k];
        end
    end

    // Shift message words in, then expanded words during the rounds
    always_ff @(posedge i_clk) begin
        if (load_word) begin
            r_win <= {i_head.word, r_win[BLOCK_WORDS-1:1]};
        end else if (do_round) begin
            r_win <= {w_next, r_win[BLOCK_WORDS-1:1]};
        end
    end

    // Working variables
    always_ff @(posedge i_clk) begin
        if (start_block) begin
            r_vars <= base_chain;
        end else if (do_round) begin
            r_vars[4] <= r_vars[3];
            r_vars[3] <= r_vars[2];
            r_vars[2] <= {r_vars[1][1:0], r_vars[1][31:2]};
            r_vars[1] <= r_vars[0];
            r_vars[0] <= t_sum;
        end
    end

    // Chaining value: reload on message start, accumulate after each block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= INIT_HASH;
        end else if (load_word && i_head.restart) begin
            r_chain <= INIT_HASH;
        end else if (do_fold) begin
            r_chain <= fold_sum;
        end
    end

    // Round counter, digest index and emit flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round <= 7'd0;
            r_idx   <= 3'd0;
            r_emit  <= 1'b0;
        end else begin
            if (start_block) begin
                r_round <= 7'd0;
                r_emit  <= i_head.emit;
            end else if (do_round) begin
                r_round <= r_round + 7'd1;
            end
            if (do_fold) begin
                r_idx <= 3'd0;
            end else if (o_strobe) begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    // Drive the digest word under the strobe
    always_comb begin
        o_result.digest_word  = r_chain[r_idx];
        o_result.digest_index = r_idx;
        o_result.digest_last  = (r_idx == LAST_DIGEST_IDX);
    end

    a_rounds_then_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == CORE_ROUND && r_round == LAST_ROUND) |=> (r_state == CORE_FOLD))
        else $error("last round not followed by fold");

    a_digest_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> (o_result.digest_index == 3'd0))
        else $error("digest burst does not open with word zero");

    a_digest_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.digest_last) |=>
        (o_strobe && o_result.digest_index == $past(o_result.digest_index) + 3'd1))
        else $error("digest burst broken or out of order");

    a_digest_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.digest_last) |=> !o_strobe)
        else $error("digest burst runs past last word");

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SHA-1 block compression engine.
// ----------------------------------------------------------------------------
// Feeds padded word streams through the command port in bursts with random
// gaps: a short directed opening (a dropped partial block, end flags off the
// block boundary, the "abc" message), then random messages of one to three
// blocks, mixed with chained messages that carry no start flag, stray end
// flags and aborted partial blocks. A software SHA-1 core inside the digest
// board predicts every digest word, and each strobed word is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sbc_pkg::t_msg_item;
    import sbc_pkg::t_digest_item;

    // Chaining value tracker plus the queue of digest words still to come
    class sha1_digest_board;
        logic [31:0]  chain [5];
        logic [31:0]  window [16];
        logic [3:0]   word_idx;
        t_digest_item digests_due [$];
        int           words_predicted;
        int           n_errors;

        function new();
            load_initial_hash();
            word_idx = '0;
            words_predicted = 0;
            n_errors = 0;
        endfunction

        function void load_initial_hash();
            chain[0] = 32'h67452301;
            chain[1] = 32'hEFCDAB89;
            chain[2] = 32'h98BADCFE;
            chain[3] = 32'h10325476;
            chain[4] = 32'hC3D2E1F0;
        endfunction

        function logic [31:0] rotl(logic [31:0] x, int unsigned n);
            return (x << n) | (x >> (32 - n));
        endfunction

        // Run the 80 rounds over the collected block and fold into the chain
        function void compress_block();
            logic [31:0] a, b, c, d, e, w, f, k, tmp;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int t = 0; t < 80; t++) begin
                if (t < 16) begin
                    w = window[t];
                end else begin
                    w = rotl(window[(t - 3) & 15] ^ window[(t - 8) & 15] ^
                             window[(t - 14) & 15] ^ window[t & 15], 1);
                    window[t & 15] = w;
                end
                case (t / 20)
                    0: begin
                        f = d ^ (b & (c ^ d));
                        k = 32'h5A827999;
                    end
                    1: begin
                        f = b ^ c ^ d;
                        k = 32'h6ED9EBA1;
                    end
                    2: begin
                        f = (b & c) | (d & (b | c));
                        k = 32'h8F1BBCDC;
                    end
                    default: begin
                        f = b ^ c ^ d;
                        k = 32'hCA62C1D6;
                    end
                endcase
                tmp = rotl(a, 5) + f + e + w + k;
                e = d;
                d = c;
                c = rotl(b, 30);
                b = a;
                a = tmp;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        // Note one accepted item and queue the digest words it causes
        function void absorb_word(t_msg_item it);
            t_digest_item dw;
            if (it.message_start) begin
                load_initial_hash();
                word_idx = '0;
            end
            window[word_idx] = it.message_word;
            word_idx = word_idx + 4'd1;
            if (word_idx != '0) return;
            compress_block();
            if (!it.message_end) return;
            for (int n = 0; n < 5; n++) begin
                dw.digest_word  = chain[n];
                dw.digest_index = 3'(n);
                dw.digest_last  = (n == 4);
                digests_due.push_back(dw);
                words_predicted++;
            end
        endfunction

        function int pending();
            return digests_due.size();
        endfunction

        task report(string msg);
            $display("tb: mismatch at %0t: %s", $time, msg);
            n_errors++;
        endtask

        // Compare one strobed digest word with the oldest prediction
        task check_digest(t_digest_item got);
            t_digest_item want;
            if (digests_due.size() == 0) begin
                report($sformatf("unexpected digest word %h index %0d last %0b",
                                 got.digest_word, got.digest_index, got.digest_last));
                return;
            end
            want = digests_due.pop_front();
            if (got.digest_word !== want.digest_word)
                report($sformatf("digest_word %h, want %h (index %0d)",
                                 got.digest_word, want.digest_word, want.digest_index));
            if (got.digest_index !== want.digest_index)
                report($sformatf("digest_index %0d, want %0d",
                                 got.digest_index, want.digest_index));
            if (got.digest_last !== want.digest_last)
                report($sformatf("digest_last %0b, want %0b (index %0d)",
                                 got.digest_last, want.digest_last, want.digest_index));
        endtask
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         start;
    t_msg_item    i_item;
    logic         busy;
    logic         o_strobe;
    t_digest_item o_result;

    sha1_digest_board board = new();
    int burst_left = 0;
    int items_sent = 0;

    sha1_block_compress dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Free-running clock, 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Check every strobed digest word
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            board.check_digest(o_result);
    end

    // Present one item and hold it until accepted; pace in bursts
    task automatic send_word(input logic [31:0] w, input logic s, input logic e);
        t_msg_item it;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        it.message_word  = w;
        it.message_start = s;
        it.message_end   = e;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        board.absorb_word(it);
        items_sent++;
    endtask

    // Hold off the sender until every predicted digest word has come
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Whole blocks; optional start on the first word, end on the last one
    task automatic send_message(input int n_blocks, input bit with_start,
                                input bit with_end, input bit stray_ends);
        logic s, e;
        for (int b = 0; b < n_blocks; b++) begin
            for (int j = 0; j < 16; j++) begin
                s = with_start && b == 0 && j == 0;
                if (j == 15)
                    e = with_end && b == n_blocks - 1;
                else
                    e = stray_ends && $urandom_range(0, 5) == 0;
                send_word(pick_word(), s, e);
            end
        end
    endtask

    // Stimulus
    initial begin
        bit need_start;
        int sel;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Partial block with end flags off the boundary, then dropped
        send_word(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_word(32'h0000_0000, 1'b0, 1'b1);
        send_word(32'h8000_0001, 1'b0, 1'b1);
        // Restart mid-block with the padded "abc" message
        send_word(32'h6162_6380, 1'b1, 1'b0);
        for (int j = 1; j < 15; j++)
            send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(32'h0000_0018, 1'b0, 1'b1);
        drain();

        // Random messages, mostly well formed
        need_start = 1'b0;
        while (items_sent < 260 || board.words_predicted < 60) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                // Abort: partial block, the next message must restart
                for (int j = $urandom_range(1, 15); j > 0; j--)
                    send_word(pick_word(), $urandom_range(0, 3) == 0,
                              $urandom_range(0, 3) == 0);
                need_start = 1'b1;
            end else begin
                send_message(($urandom_range(0, 5) == 0) ? $urandom_range(2, 3) : 1,
                             need_start || sel != 1, sel != 2, sel == 3);
                need_start = 1'b0;
            end
            if ($urandom_range(0, 7) == 0)
                drain();
        end

        // Let the last digest and any trailing compression finish
        start <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (board.n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
sv/sbc_pkg.sv
sv/sbc_front.sv
sv/sbc_queue.sv
sv/sbc_core.sv
sv/sha1_block_compress.sv
tb/sv/testbench.sv
